### hdl/trilateration_2d_ema_core_assert.svh
// Assertion macros shared by the trilateration core modules.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef TRILATERATION_2D_EMA_CORE_ASSERT_SVH
`define TRILATERATION_2D_EMA_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition that must hold at every clock edge outside reset.
`define TRI2D_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define TRI2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define TRI2D_ASSERT(lbl, expr, msg)
`define TRI2D_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hdl/tri2d_pkg.sv
// Shared types, constants and register indexes of the trilateration core.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package tri2d_pkg;

  // Field widths.
  localparam int DIST_W    = 16;
  localparam int OUT_W     = 24;
  localparam int COEF_W    = 32;
  localparam int OFFS_W    = 24;
  localparam int MEAN_W    = 32;
  localparam int FRAC_W    = 24;   // fractional bits of the coefficients
  localparam int AVG_FRAC  = 8;    // fractional bits of the running mean
  localparam int ALPHA_W   = 10;   // signed width that holds weights up to 256
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Parameter defaults.
  localparam int ALPHA_Q8_DEF  = 77;
  localparam int DIST_BITS_DEF = 16;

  // Sequencing.
  localparam int NUM_DIST     = 4;
  localparam int NUM_TERMS    = 3;    // difference terms per axis
  localparam int NUM_COEF     = 6;
  localparam int STEP_W       = 3;
  localparam int DIDX_W       = 2;
  localparam int TERM_IDX_W   = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X1  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X2  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X3  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y3  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd7;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_E3,
    S_MAC,
    S_FIN,
    S_DIFF,
    S_BLEND,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ,
    OP_E3,
    OP_MAC,
    OP_FIN,
    OP_DIFF,
    OP_BLEND,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

### hdl/tri2d_ctrl.sv
// Sequencer of the trilateration core: steps the datapath through one word.
// Depends on tri2d_pkg and the assertion header.
`default_nettype none
`include "trilateration_2d_ema_core_assert.svh"

module tri2d_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire tri2d_pkg::stat_t stat,
  output tri2d_pkg::cmd_t    cmd
);

  localparam logic [tri2d_pkg::STEP_W-1:0] SQ_LAST =
    tri2d_pkg::STEP_W'(tri2d_pkg::NUM_DIST - 1);
  localparam logic [tri2d_pkg::STEP_W-1:0] MAC_LAST =
    tri2d_pkg::STEP_W'(tri2d_pkg::NUM_COEF);

  tri2d_pkg::state_t             state_r, state_nxt;
  logic [tri2d_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tri2d_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = tri2d_pkg::OP_NONE;
    cmd.step  = cnt_r;
    in_stall  = (state_r != tri2d_pkg::S_IDLE);
    case (state_r)
      tri2d_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op    = tri2d_pkg::OP_LOAD;
          state_nxt = tri2d_pkg::S_SQ;
          cnt_nxt   = '0;
        end
      end
      tri2d_pkg::S_SQ: begin
        cmd.op = tri2d_pkg::OP_SQ;
        if (cnt_r == SQ_LAST) begin
          state_nxt = tri2d_pkg::S_E3;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tri2d_pkg::S_E3: begin
        cmd.op    = tri2d_pkg::OP_E3;
        state_nxt = tri2d_pkg::S_MAC;
        cnt_nxt   = '0;
      end
      tri2d_pkg::S_MAC: begin
        cmd.op = tri2d_pkg::OP_MAC;
        if (cnt_r == MAC_LAST) begin
          state_nxt = tri2d_pkg::S_FIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tri2d_pkg::S_FIN: begin
        cmd.op    = tri2d_pkg::OP_FIN;
        state_nxt = tri2d_pkg::S_DIFF;
      end
      tri2d_pkg::S_DIFF: begin
        cmd.op    = tri2d_pkg::OP_DIFF;
        state_nxt = tri2d_pkg::S_BLEND;
      end
      tri2d_pkg::S_BLEND: begin
        cmd.op    = tri2d_pkg::OP_BLEND;
        state_nxt = tri2d_pkg::S_OUT;
      end
      tri2d_pkg::S_OUT: begin
        // The result register may still hold an earlier word.
        if (!stat.out_busy) begin
          cmd.op    = tri2d_pkg::OP_OUT;
          state_nxt = tri2d_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tri2d_pkg::S_IDLE;
      end
    endcase
  end

  `TRI2D_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == tri2d_pkg::S_SQ && cnt_r == '0, "accepted word did not start the square steps")
  `TRI2D_ASSERT(a_mac_bound, state_r != tri2d_pkg::S_MAC || cnt_r <= MAC_LAST, "product counter overran")
  `TRI2D_ASSERT_NEXT(a_out_wait, state_r == tri2d_pkg::S_OUT && stat.out_busy, state_r == tri2d_pkg::S_OUT, "result overwritten while the output was stalled")

endmodule

`default_nettype wire

### hdl/tri2d_dp.sv
// Datapath of the trilateration core: configuration registers, one shared
// multiplier with accumulators, rounding, saturation, averaging and result register.
// Depends on tri2d_pkg and the assertion header.
`default_nettype none
`include "trilateration_2d_ema_core_assert.svh"

module tri2d_dp #(
  parameter int ALPHA_Q8  = tri2d_pkg::ALPHA_Q8_DEF,
  parameter int DIST_BITS = tri2d_pkg::DIST_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire tri2d_pkg::cmd_t                      cmd,
  output tri2d_pkg::stat_t                          stat,
  input  wire logic [tri2d_pkg::DIST_W-1:0]         in_dist0,
  input  wire logic [tri2d_pkg::DIST_W-1:0]         in_dist1,
  input  wire logic [tri2d_pkg::DIST_W-1:0]         in_dist2,
  input  wire logic [tri2d_pkg::DIST_W-1:0]         in_dist3,
  input  wire logic                                 in_restart,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [tri2d_pkg::OUT_W-1:0]        out_raw_x,
  output logic signed [tri2d_pkg::OUT_W-1:0]        out_raw_y,
  output logic signed [tri2d_pkg::OUT_W-1:0]        out_avg_x,
  output logic signed [tri2d_pkg::OUT_W-1:0]        out_avg_y,
  output logic                                      out_saturated,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [tri2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tri2d_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DW     = (DIST_BITS < tri2d_pkg::DIST_W) ? DIST_BITS : tri2d_pkg::DIST_W;
  localparam int SQ_W   = 2 * DW;
  localparam int EW     = SQ_W + 1;
  localparam int PW     = EW + tri2d_pkg::COEF_W;
  localparam int ACC_W  = PW + 2;
  localparam int QW     = ACC_W - tri2d_pkg::FRAC_W;
  localparam int OW     = tri2d_pkg::OUT_W;
  localparam int MW     = tri2d_pkg::MEAN_W;
  localparam int AF     = tri2d_pkg::AVG_FRAC;
  localparam int DIFF_W = MW + 1;
  localparam int BL_W   = DIFF_W + tri2d_pkg::ALPHA_W;
  localparam int SW     = tri2d_pkg::STEP_W;
  localparam int TW     = tri2d_pkg::TERM_IDX_W;
  // A difference is written in the step after the one that started its square.
  localparam logic [SW-1:0] SQ_LAG  = SW'(2);
  localparam logic [SW-1:0] N_TERMS = SW'(tri2d_pkg::NUM_TERMS);
  localparam logic [SW-1:0] N_COEF  = SW'(tri2d_pkg::NUM_COEF);

  localparam logic signed [tri2d_pkg::ALPHA_W-1:0] ALPHA_S = tri2d_pkg::ALPHA_W'(ALPHA_Q8);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (tri2d_pkg::FRAC_W - 1);
  localparam logic signed [QW-1:0] Q_MAX = {{(QW-OW){1'b0}}, tri2d_pkg::OUT_MAX};
  localparam logic signed [QW-1:0] Q_MIN = {{(QW-OW){1'b1}}, tri2d_pkg::OUT_MIN};
  localparam logic [MW-1:0] AVG_HALF = MW'(1) << (AF - 1);
  localparam logic signed [BL_W-1:0] BL_HALF = BL_W'(1) << (AF - 1);

  typedef struct packed {
    logic signed [OW-1:0] val;
    logic                 sat;
  } fin_t;

  // Round half up to whole millimetres and clip to the output range.
  function automatic fin_t finish(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] s;
    logic signed [QW-1:0]    q;
    fin_t                    r;
    s     = acc + RND_HALF;
    q     = s[ACC_W-1:tri2d_pkg::FRAC_W];
    r.val = q[OW-1:0];
    r.sat = 1'b0;
    if (q > Q_MAX) begin
      r.val = tri2d_pkg::OUT_MAX;
      r.sat = 1'b1;
    end else if (q < Q_MIN) begin
      r.val = tri2d_pkg::OUT_MIN;
      r.sat = 1'b1;
    end
    return r;
  endfunction

  // Configuration and averaging state.
  logic signed [tri2d_pkg::COEF_W-1:0] coef_r [tri2d_pkg::NUM_COEF];
  logic signed [tri2d_pkg::OFFS_W-1:0] off_x_r, off_y_r;
  logic signed [MW-1:0]                mean_x_r, mean_y_r;
  logic                                out_valid_r;

  // Working registers of one word.
  logic [DW-1:0]            d_r [tri2d_pkg::NUM_DIST];
  logic                     rs_r;
  logic [SQ_W-1:0]          sq0_r;
  logic signed [EW-1:0]     e_r [tri2d_pkg::NUM_TERMS];
  logic signed [PW-1:0]     prod_r;
  logic signed [ACC_W-1:0]  acc_x_r, acc_y_r;
  logic signed [OW-1:0]     raw_x_r, raw_y_r;
  logic                     sat_r;
  logic signed [DIFF_W-1:0] diff_x_r, diff_y_r;

  // Result register.
  logic signed [OW-1:0] out_raw_x_r, out_raw_y_r, out_avg_x_r, out_avg_y_r;
  logic                 out_sat_r;

  // Shared multiplier operands.
  logic signed [EW-1:0]                op_a;
  logic signed [tri2d_pkg::COEF_W-1:0] op_b;
  logic [tri2d_pkg::DIDX_W-1:0]        d_idx;
  logic [TW-1:0]                       e_idx;
  logic signed [EW-1:0]                e_new;
  logic signed [ACC_W-1:0]             prod_ext;
  fin_t                                fin_x, fin_y;
  logic signed [BL_W-1:0]              bl_x, bl_y;
  logic [MW-1:0]                       avg_x_sum, avg_y_sum;

  assign d_idx    = cmd.step[tri2d_pkg::DIDX_W-1:0];
  assign e_new    = $signed({1'b0, sq0_r}) - $signed({1'b0, prod_r[SQ_W-1:0]});
  assign prod_ext = {{(ACC_W-PW){prod_r[PW-1]}}, prod_r};
  assign fin_x    = finish(acc_x_r);
  assign fin_y    = finish(acc_y_r);
  assign bl_x     = diff_x_r * ALPHA_S + BL_HALF;
  assign bl_y     = diff_y_r * ALPHA_S + BL_HALF;
  assign avg_x_sum = mean_x_r + AVG_HALF;
  assign avg_y_sum = mean_y_r + AVG_HALF;

  always_comb begin
    op_a  = '0;
    op_b  = '0;
    e_idx = TW'(cmd.step);
    if (cmd.step >= N_TERMS) begin
      e_idx = TW'(cmd.step - N_TERMS);
    end
    if (cmd.op == tri2d_pkg::OP_SQ) begin
      op_a = $signed({{(EW-DW){1'b0}}, d_r[d_idx]});
      op_b = $signed({{(tri2d_pkg::COEF_W-DW){1'b0}}, d_r[d_idx]});
    end else if (cmd.step < N_COEF) begin
      op_a = e_r[e_idx];
      op_b = coef_r[cmd.step];
    end
  end

  // Configuration registers, the running mean and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tri2d_pkg::NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
      off_x_r     <= '0;
      off_y_r     <= '0;
      mean_x_r    <= '0;
      mean_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          tri2d_pkg::REG_COEF_X1, tri2d_pkg::REG_COEF_X2, tri2d_pkg::REG_COEF_X3,
          tri2d_pkg::REG_COEF_Y1, tri2d_pkg::REG_COEF_Y2, tri2d_pkg::REG_COEF_Y3: begin
            coef_r[cfg_index] <= cfg_data;
          end
          tri2d_pkg::REG_OFFSET_X: begin
            off_x_r <= cfg_data[tri2d_pkg::OFFS_W-1:0];
          end
          tri2d_pkg::REG_OFFSET_Y: begin
            off_y_r <= cfg_data[tri2d_pkg::OFFS_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cmd.op == tri2d_pkg::OP_BLEND) begin
        if (rs_r) begin
          mean_x_r <= {raw_x_r, {AF{1'b0}}};
          mean_y_r <= {raw_y_r, {AF{1'b0}}};
        end else begin
          mean_x_r <= mean_x_r + bl_x[AF+MW-1:AF];
          mean_y_r <= mean_y_r + bl_y[AF+MW-1:AF];
        end
      end
      if (cmd.op == tri2d_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-word working registers and the result register.
  always_ff @(posedge clk) begin
    case (cmd.op)
      tri2d_pkg::OP_LOAD: begin
        d_r[0] <= in_dist0[DW-1:0];
        d_r[1] <= in_dist1[DW-1:0];
        d_r[2] <= in_dist2[DW-1:0];
        d_r[3] <= in_dist3[DW-1:0];
        rs_r   <= in_restart;
      end
      tri2d_pkg::OP_SQ: begin
        prod_r <= op_a * op_b;
        if (cmd.step == SW'(1)) begin
          sq0_r <= prod_r[SQ_W-1:0];
        end else if (cmd.step >= SQ_LAG) begin
          e_r[TW'(cmd.step - SQ_LAG)] <= e_new;
        end
      end
      tri2d_pkg::OP_E3: begin
        e_r[TW'(N_TERMS - 1'b1)] <= e_new;
        acc_x_r <= {{(ACC_W-tri2d_pkg::OFFS_W-tri2d_pkg::FRAC_W){off_x_r[tri2d_pkg::OFFS_W-1]}},
                    off_x_r, {tri2d_pkg::FRAC_W{1'b0}}};
        acc_y_r <= {{(ACC_W-tri2d_pkg::OFFS_W-tri2d_pkg::FRAC_W){off_y_r[tri2d_pkg::OFFS_W-1]}},
                    off_y_r, {tri2d_pkg::FRAC_W{1'b0}}};
      end
      tri2d_pkg::OP_MAC: begin
        if (cmd.step < N_COEF) begin
          prod_r <= op_a * op_b;
        end
        // The product started in the previous step lands in its axis sum.
        if (cmd.step != '0) begin
          if (cmd.step <= N_TERMS) begin
            acc_x_r <= acc_x_r + prod_ext;
          end else begin
            acc_y_r <= acc_y_r + prod_ext;
          end
        end
      end
      tri2d_pkg::OP_FIN: begin
        raw_x_r <= fin_x.val;
        raw_y_r <= fin_y.val;
        sat_r   <= fin_x.sat | fin_y.sat;
      end
      tri2d_pkg::OP_DIFF: begin
        diff_x_r <= $signed({raw_x_r[OW-1], raw_x_r, {AF{1'b0}}})
                  - $signed({mean_x_r[MW-1], mean_x_r});
        diff_y_r <= $signed({raw_y_r[OW-1], raw_y_r, {AF{1'b0}}})
                  - $signed({mean_y_r[MW-1], mean_y_r});
      end
      tri2d_pkg::OP_OUT: begin
        out_raw_x_r <= raw_x_r;
        out_raw_y_r <= raw_y_r;
        out_avg_x_r <= avg_x_sum[MW-1:AF];
        out_avg_y_r <= avg_y_sum[MW-1:AF];
        out_sat_r   <= sat_r;
      end
      default: begin
      end
    endcase
  end

  assign stat.out_busy = out_valid_r & out_stall;
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_raw_x     = out_raw_x_r;
  assign out_raw_y     = out_raw_y_r;
  assign out_avg_x     = out_avg_x_r;
  assign out_avg_y     = out_avg_y_r;
  assign out_saturated = out_sat_r;

  `TRI2D_ASSERT(a_sat_bound, !(out_valid_r && out_sat_r) || out_raw_x_r == tri2d_pkg::OUT_MAX || out_raw_x_r == tri2d_pkg::OUT_MIN || out_raw_y_r == tri2d_pkg::OUT_MAX || out_raw_y_r == tri2d_pkg::OUT_MIN, "saturated flag without a clipped position")
  `TRI2D_ASSERT_NEXT(a_restart_load, cmd.op == tri2d_pkg::OP_BLEND && rs_r, mean_x_r[AF-1:0] == '0 && mean_x_r[MW-1:AF] == raw_x_r && mean_y_r[AF-1:0] == '0 && mean_y_r[MW-1:AF] == raw_y_r, "restart did not load the mean")
  `TRI2D_ASSERT(a_out_free, cmd.op != tri2d_pkg::OP_OUT || !(out_valid_r && out_stall), "result register loaded while stalled")

endmodule

`default_nettype wire

### hdl/trilateration_2d_ema_core.sv
// Top level of the 2D four-anchor trilateration core with moving average.
// Depends on tri2d_pkg, tri2d_ctrl and tri2d_dp.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   in      | input     | in_valid / in_stall   | in_dist0..3 (mm), in_restart
//   out     | output    | out_valid / out_stall | out_raw_x/y, out_avg_x/y (mm), out_saturated
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word runs from acceptance to the next acceptance through four square steps,
// one difference step, seven multiply-accumulate steps, then rounding, the averaging
// difference, blend and load, plus the idle cycle that accepts the next word.
// The single shared 33x32 multiplier carries the squares and all six coefficient
// products, so these steps run one after another.
// Reset is synchronous and active low; it clears coefficients, offsets, mean and output valid.
// A stalled result holds its register; a finished word waits in the load step until
// the output register frees, and the next input word is accepted only after it is loaded.
`default_nettype none

module trilateration_2d_ema_core #(
  parameter int ALPHA_Q8  = tri2d_pkg::ALPHA_Q8_DEF,
  parameter int DIST_BITS = tri2d_pkg::DIST_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [tri2d_pkg::DIST_W-1:0]         in_dist0,
  input  wire logic [tri2d_pkg::DIST_W-1:0]         in_dist1,
  input  wire logic [tri2d_pkg::DIST_W-1:0]         in_dist2,
  input  wire logic [tri2d_pkg::DIST_W-1:0]         in_dist3,
  input  wire logic                                 in_restart,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [tri2d_pkg::OUT_W-1:0]        out_raw_x,
  output logic signed [tri2d_pkg::OUT_W-1:0]        out_raw_y,
  output logic signed [tri2d_pkg::OUT_W-1:0]        out_avg_x,
  output logic signed [tri2d_pkg::OUT_W-1:0]        out_avg_y,
  output logic                                      out_saturated,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [tri2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tri2d_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // The controller only sequences; all arithmetic and storage sit in the datapath.
  tri2d_pkg::cmd_t  cmd;
  tri2d_pkg::stat_t stat;

  tri2d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tri2d_dp #(
    .ALPHA_Q8  (ALPHA_Q8),
    .DIST_BITS (DIST_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_dist0      (in_dist0),
    .in_dist1      (in_dist1),
    .in_dist2      (in_dist2),
    .in_dist3      (in_dist3),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_raw_x     (out_raw_x),
    .out_raw_y     (out_raw_y),
    .out_avg_x     (out_avg_x),
    .out_avg_y     (out_avg_y),
    .out_saturated (out_saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

endmodule

`default_nettype wire

### tb/tb_trilateration_2d_ema_core.sv
// Self-checking testbench for trilateration_2d_ema_core: four-anchor position solve plus averaging.
// Depends on tri2d_pkg and the core RTL only; it predicts every result word on its own.
module tb_trilateration_2d_ema_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ALPHA         = tri2d_pkg::ALPHA_Q8_DEF;
  localparam int DIST_BITS     = tri2d_pkg::DIST_BITS_DEF;
  localparam int SETTLE_CYCLES = 40;    // longer than the core takes for one word
  localparam int GAP_PCT       = 17;    // percent of cycles in which a side idles
  localparam int MAX_REPORTS   = 10;
  localparam int LIMIT_NS      = 10_000_000;

  localparam logic [tri2d_pkg::DIST_W-1:0] DIST_MASK =
    (DIST_BITS >= tri2d_pkg::DIST_W) ? {tri2d_pkg::DIST_W{1'b1}} :
                                       tri2d_pkg::DIST_W'((64'd1 << DIST_BITS) - 1);
  localparam logic signed [tri2d_pkg::COEF_W-1:0] COEF_TOP = 32'sh7FFF_FFFF;
  localparam logic signed [tri2d_pkg::COEF_W-1:0] COEF_BOT = 32'sh8000_0000;
  localparam logic signed [tri2d_pkg::COEF_W-1:0] COEF_HALF = 32'sh0080_0000;   // 0.5 in Q8.24

  // One set of ranges as it enters the core.
  typedef struct {
    logic [tri2d_pkg::DIST_W-1:0] d0, d1, d2, d3;
    logic                         restart;
  } range_set_t;

  // One position fix as it leaves the core.
  typedef struct {
    logic signed [tri2d_pkg::OUT_W-1:0] raw_x, raw_y, avg_x, avg_y;
    logic                               saturated;
  } fix_t;

  typedef enum {SET_REALISTIC, SET_SMALL, SET_WIDE, SET_CORNERS} setting_kind_t;

  // Every input of the core is known from time zero.
  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_valid   = 1'b0;
  logic [tri2d_pkg::DIST_W-1:0] in_dist0   = '0;
  logic [tri2d_pkg::DIST_W-1:0] in_dist1   = '0;
  logic [tri2d_pkg::DIST_W-1:0] in_dist2   = '0;
  logic [tri2d_pkg::DIST_W-1:0] in_dist3   = '0;
  logic                         in_restart = 1'b0;
  logic                         out_stall  = 1'b0;
  logic                         cfg_valid  = 1'b0;
  logic [tri2d_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tri2d_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic                               in_stall;
  logic                               out_valid;
  logic signed [tri2d_pkg::OUT_W-1:0] out_raw_x, out_raw_y, out_avg_x, out_avg_y;
  logic                               out_saturated;
  logic                               cfg_ready;

  // Words waiting to be driven, and the fixes the core owes us, oldest first.
  range_set_t pending_ranges[$];
  fix_t       expected_fixes[$];
  range_set_t drive_word;
  range_set_t taken_word;
  fix_t       want;
  logic       range_taken = 1'b0;   // the input word on the bus went in at the last edge
  bit         gapless     = 1'b0;   // suppresses all idling on both sides

  // Our copy of the register file and of the running mean (Q.8 millimetres).
  logic signed [tri2d_pkg::COEF_W-1:0] coef_q24 [tri2d_pkg::NUM_COEF];
  logic signed [tri2d_pkg::OFFS_W-1:0] offs_x = '0;
  logic signed [tri2d_pkg::OFFS_W-1:0] offs_y = '0;
  longint                              mean_x_q8 = 0;
  longint                              mean_y_q8 = 0;

  // Staging area for the next register setting.
  logic signed [tri2d_pkg::COEF_W-1:0] stage_coef [tri2d_pkg::NUM_COEF];
  logic signed [tri2d_pkg::OFFS_W-1:0] stage_ox, stage_oy;

  int errors        = 0;
  int words_checked = 0;
  int sat_seen      = 0;
  int restarts      = 0;
  int settings      = 0;

  trilateration_2d_ema_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_dist0     (in_dist0),
    .in_dist1     (in_dist1),
    .in_dist2     (in_dist2),
    .in_dist3     (in_dist3),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_raw_x    (out_raw_x),
    .out_raw_y    (out_raw_y),
    .out_avg_x    (out_avg_x),
    .out_avg_y    (out_avg_y),
    .out_saturated(out_saturated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    for (int k = 0; k < tri2d_pkg::NUM_COEF; k++) begin
      coef_q24[k] = '0;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Position predictor
  // ---------------------------------------------------------------------------------------------

  // Rounds a Q.24 sum half up to whole millimetres and clips it to the 24-bit output range.
  function automatic logic signed [tri2d_pkg::OUT_W-1:0] round_clip(
      input logic signed [127:0] acc, inout bit clipped);
    logic signed [127:0] q;
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    hi_lim = tri2d_pkg::OUT_MAX;
    lo_lim = tri2d_pkg::OUT_MIN;
    q = (acc + (128'sd1 <<< (tri2d_pkg::FRAC_W - 1))) >>> tri2d_pkg::FRAC_W;
    if (q > hi_lim) begin
      clipped = 1'b1;
      return tri2d_pkg::OUT_MAX;
    end
    if (q < lo_lim) begin
      clipped = 1'b1;
      return tri2d_pkg::OUT_MIN;
    end
    return q[tri2d_pkg::OUT_W-1:0];
  endfunction

  // One step of the moving average; a restart loads the raw position outright.
  function automatic longint ema_step(input longint mean,
                                      input logic signed [tri2d_pkg::OUT_W-1:0] raw,
                                      input logic restart);
    longint target;
    target = longint'(raw) * (longint'(1) << tri2d_pkg::AVG_FRAC);
    if (restart) begin
      return target;
    end
    return mean + ((longint'(ALPHA) * (target - mean) + 128) >>> tri2d_pkg::AVG_FRAC);
  endfunction

  // Solves the position for one range set and advances the running mean.
  function automatic fix_t locate(input range_set_t r);
    longint                       sq [tri2d_pkg::NUM_DIST];
    logic [tri2d_pkg::DIST_W-1:0] d  [tri2d_pkg::NUM_DIST];
    logic signed [127:0]          acc_x, acc_y, e_w, c_w;
    bit                           clipped;
    fix_t                         f;
    int                           i;
    clipped = 1'b0;
    d[0] = r.d0 & DIST_MASK;
    d[1] = r.d1 & DIST_MASK;
    d[2] = r.d2 & DIST_MASK;
    d[3] = r.d3 & DIST_MASK;
    for (i = 0; i < tri2d_pkg::NUM_DIST; i++) begin
      sq[i] = longint'(d[i]) * longint'(d[i]);
    end
    // The offsets enter the sum already scaled to Q.24.
    acc_x = offs_x;
    acc_y = offs_y;
    acc_x = acc_x <<< tri2d_pkg::FRAC_W;
    acc_y = acc_y <<< tri2d_pkg::FRAC_W;
    for (i = 0; i < tri2d_pkg::NUM_TERMS; i++) begin
      e_w = sq[0] - sq[i+1];
      c_w = coef_q24[i];
      acc_x = acc_x + e_w * c_w;
      c_w = coef_q24[tri2d_pkg::NUM_TERMS + i];
      acc_y = acc_y + e_w * c_w;
    end
    f.raw_x = round_clip(acc_x, clipped);
    f.raw_y = round_clip(acc_y, clipped);
    f.saturated = clipped;
    mean_x_q8 = ema_step(mean_x_q8, f.raw_x, r.restart);
    mean_y_q8 = ema_step(mean_y_q8, f.raw_y, r.restart);
    f.avg_x = tri2d_pkg::OUT_W'((mean_x_q8 + 128) >>> tri2d_pkg::AVG_FRAC);
    f.avg_y = tri2d_pkg::OUT_W'((mean_y_q8 + 128) >>> tri2d_pkg::AVG_FRAC);
    return f;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Input side: the driver presents words at the falling edge, and the acceptance of each word
  // is caught at the rising edge, where its fix is predicted at once.
  // ---------------------------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || range_taken) begin
      // The bus is free: either present the next word or leave it idle.
      if (pending_ranges.size() > 0 && (gapless || $urandom_range(99) >= GAP_PCT)) begin
        drive_word = pending_ranges.pop_front();
        in_dist0   <= drive_word.d0;
        in_dist1   <= drive_word.d1;
        in_dist2   <= drive_word.d2;
        in_dist3   <= drive_word.d3;
        in_restart <= drive_word.restart;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    range_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      taken_word.d0      = in_dist0;
      taken_word.d1      = in_dist1;
      taken_word.d2      = in_dist2;
      taken_word.d3      = in_dist3;
      taken_word.restart = in_restart;
      if (in_restart) begin
        restarts++;
      end
      expected_fixes.push_back(locate(taken_word));
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Output side: random back-pressure, and every accepted fix is checked against the oldest
  // prediction field by field.
  // ---------------------------------------------------------------------------------------------

  always @(negedge clk) begin
    out_stall <= !gapless && ($urandom_range(99) < GAP_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_fixes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected result word: raw %0d,%0d avg %0d,%0d sat %0b",
                   out_raw_x, out_raw_y, out_avg_x, out_avg_y, out_saturated);
        end
      end else begin
        want = expected_fixes.pop_front();
        words_checked++;
        if (out_saturated) begin
          sat_seen++;
        end
        if (out_raw_x !== want.raw_x || out_raw_y !== want.raw_y ||
            out_avg_x !== want.avg_x || out_avg_y !== want.avg_y ||
            out_saturated !== want.saturated) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("mismatch on result word %0d at %0t ns:", words_checked, $realtime);
            $display("  got    raw %0d,%0d avg %0d,%0d sat %0b",
                     out_raw_x, out_raw_y, out_avg_x, out_avg_y, out_saturated);
            $display("  wanted raw %0d,%0d avg %0d,%0d sat %0b",
                     want.raw_x, want.raw_y, want.avg_x, want.avg_y, want.saturated);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------------

  task automatic push_range(input logic [tri2d_pkg::DIST_W-1:0] a,
                            input logic [tri2d_pkg::DIST_W-1:0] b,
                            input logic [tri2d_pkg::DIST_W-1:0] c,
                            input logic [tri2d_pkg::DIST_W-1:0] d,
                            input logic rs);
    range_set_t w;
    w.d0 = a;
    w.d1 = b;
    w.d2 = c;
    w.d3 = d;
    w.restart = rs;
    pending_ranges.push_back(w);
  endtask

  // Waits until every queued word has gone in and every fix has come out, then lets the core
  // settle so that a register write never lands on a word in flight.
  task automatic drain();
    while (pending_ranges.size() != 0 || in_valid || expected_fixes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; our copy changes at the edge where the core takes the word.
  task automatic write_reg(input logic [tri2d_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tri2d_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tri2d_pkg::REG_COEF_X1:  coef_q24[0] = data;
      tri2d_pkg::REG_COEF_X2:  coef_q24[1] = data;
      tri2d_pkg::REG_COEF_X3:  coef_q24[2] = data;
      tri2d_pkg::REG_COEF_Y1:  coef_q24[3] = data;
      tri2d_pkg::REG_COEF_Y2:  coef_q24[4] = data;
      tri2d_pkg::REG_COEF_Y3:  coef_q24[5] = data;
      tri2d_pkg::REG_OFFSET_X: offs_x = data[tri2d_pkg::OFFS_W-1:0];
      tri2d_pkg::REG_OFFSET_Y: offs_y = data[tri2d_pkg::OFFS_W-1:0];
      default: ;
    endcase
  endtask

  // Writes the staged setting into all eight registers. The offset registers only keep their
  // low 24 bits, so the upper data bits carry noise.
  task automatic apply_setting();
    int i;
    for (i = 0; i < tri2d_pkg::NUM_COEF; i++) begin
      write_reg(tri2d_pkg::REG_COEF_X1 + tri2d_pkg::CFG_IDX_W'(i), stage_coef[i]);
    end
    write_reg(tri2d_pkg::REG_OFFSET_X, {8'($urandom), stage_ox});
    write_reg(tri2d_pkg::REG_OFFSET_Y, {8'($urandom), stage_oy});
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic int spread(input int mag);
    return int'($urandom_range(2 * mag)) - mag;
  endfunction

  function automatic logic [tri2d_pkg::DIST_W-1:0] near(input int base);
    int v;
    v = base + spread(8000);
    if (v < 0) begin
      v = 0;
    end
    if (v > 65535) begin
      v = 65535;
    end
    return v[tri2d_pkg::DIST_W-1:0];
  endfunction

  function automatic logic signed [tri2d_pkg::COEF_W-1:0] corner_coef();
    case ($urandom_range(4))
      0:       return COEF_TOP;
      1:       return COEF_BOT;
      2:       return '0;
      3:       return ($urandom_range(1) != 0) ? 32'sd1 : -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [tri2d_pkg::OFFS_W-1:0] corner_offset();
    case ($urandom_range(3))
      0:       return tri2d_pkg::OUT_MAX;
      1:       return tri2d_pkg::OUT_MIN;
      2:       return '0;
      default: return tri2d_pkg::OFFS_W'($urandom);
    endcase
  endfunction

  // Realistic settings keep most positions inside the output range; wide and corner settings
  // drive the sum far past it in both directions.
  task automatic random_setting(input setting_kind_t kind);
    int i;
    for (i = 0; i < tri2d_pkg::NUM_COEF; i++) begin
      case (kind)
        SET_REALISTIC: stage_coef[i] = spread(1 << 14);
        SET_SMALL:     stage_coef[i] = spread(1 << 10);
        SET_WIDE:      stage_coef[i] = $urandom;
        default:       stage_coef[i] = corner_coef();
      endcase
    end
    case (kind)
      SET_REALISTIC: begin
        stage_ox = tri2d_pkg::OFFS_W'(spread(1 << 20));
        stage_oy = tri2d_pkg::OFFS_W'(spread(1 << 20));
      end
      SET_SMALL: begin
        stage_ox = tri2d_pkg::OFFS_W'(spread(1 << 16));
        stage_oy = tri2d_pkg::OFFS_W'(spread(1 << 16));
      end
      SET_WIDE: begin
        stage_ox = tri2d_pkg::OFFS_W'($urandom);
        stage_oy = tri2d_pkg::OFFS_W'($urandom);
      end
      default: begin
        stage_ox = corner_offset();
        stage_oy = corner_offset();
      end
    endcase
    apply_setting();
  endtask

  // Mostly plausible range sets around a common distance, with full-range noise and range
  // extremes mixed in; restarts are sprinkled in so the average is both reloaded and blended.
  task automatic random_phase(input int count);
    int n;
    int pick;
    int base;
    range_set_t w;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        base = $urandom_range(40000, 200);
        w.d0 = near(base);
        w.d1 = near(base);
        w.d2 = near(base);
        w.d3 = near(base);
      end else if (pick < 93) begin
        w.d0 = tri2d_pkg::DIST_W'($urandom);
        w.d1 = tri2d_pkg::DIST_W'($urandom);
        w.d2 = tri2d_pkg::DIST_W'($urandom);
        w.d3 = tri2d_pkg::DIST_W'($urandom);
      end else begin
        w.d0 = ($urandom_range(1) != 0) ? '1 : '0;
        w.d1 = ($urandom_range(1) != 0) ? '1 : '0;
        w.d2 = ($urandom_range(2) == 0) ? tri2d_pkg::DIST_W'($urandom) : '1;
        w.d3 = ($urandom_range(2) == 0) ? tri2d_pkg::DIST_W'($urandom) : '0;
      end
      w.restart = ($urandom_range(99) < 8);
      pending_ranges.push_back(w);
    end
  endtask

  // ---------------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------------

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Registers still at their reset value: every position is zero.
    push_range(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    push_range(16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b0);
    push_range(16'd12345, 16'd0, 16'd65535, 16'd40000, 1'b0);
    drain();

    // Weights of exactly one half: a difference of one lands on a half millimetre, which has
    // to round toward plus infinity in both signs.
    stage_coef = '{COEF_HALF, 32'sd0, 32'sd0, -COEF_HALF, 32'sd0, 32'sd0};
    stage_ox = '0;
    stage_oy = '0;
    apply_setting();
    push_range(16'd1, 16'd0, 16'd0, 16'd0, 1'b1);
    push_range(16'd0, 16'd1, 16'd0, 16'd0, 1'b0);
    push_range(16'd65535, 16'd65534, 16'd0, 16'd0, 1'b0);
    drain();

    // Largest weights and offsets: clipping at both ends, and an offset alone at the top.
    stage_coef = '{COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP};
    stage_ox = tri2d_pkg::OUT_MAX;
    stage_oy = tri2d_pkg::OUT_MAX;
    apply_setting();
    push_range(16'd65535, 16'd0, 16'd0, 16'd0, 1'b1);
    push_range(16'd0, 16'd65535, 16'd65535, 16'd65535, 1'b0);
    push_range(16'd777, 16'd777, 16'd777, 16'd777, 1'b0);
    push_range(16'd1, 16'd0, 16'd0, 16'd0, 1'b0);
    drain();

    // Most negative weights and offsets.
    stage_coef = '{COEF_BOT, COEF_BOT, COEF_BOT, COEF_BOT, COEF_BOT, COEF_BOT};
    stage_ox = tri2d_pkg::OUT_MIN;
    stage_oy = tri2d_pkg::OUT_MIN;
    apply_setting();
    push_range(16'd65535, 16'd0, 16'd0, 16'd0, 1'b1);
    push_range(16'd0, 16'd65535, 16'd65535, 16'd65535, 1'b0);
    push_range(16'd777, 16'd777, 16'd777, 16'd777, 1'b0);
    push_range(16'd1, 16'd0, 16'd0, 16'd0, 1'b0);
    drain();

    // Random part, one register setting per phase.
    random_setting(SET_REALISTIC);
    random_phase(220);
    drain();
    random_setting(SET_SMALL);
    random_phase(220);
    drain();
    random_setting(SET_WIDE);
    random_phase(200);
    drain();
    // Back-to-back words with no idling on either side.
    random_setting(SET_REALISTIC);
    gapless = 1'b1;
    random_phase(240);
    drain();
    gapless = 1'b0;
    random_setting(SET_CORNERS);
    random_phase(200);
    drain();
    random_setting(SET_SMALL);
    random_phase(220);
    drain();
    random_setting(SET_REALISTIC);
    random_phase(250);
    drain();

    $display("Checked %0d position words under %0d register settings.", words_checked, settings);
    $display("Of those, %0d were clipped and %0d restarted the average; %0d errors.",
             sat_seen, restarts, errors);
    if (errors == 0) begin
      $display("** trilateration_2d_ema_core: PASSED **");
    end else begin
      $display("** trilateration_2d_ema_core: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, so only a hung core trips it.
  initial begin
    #(LIMIT_NS);
    $display("Timed out with %0d words queued and %0d results outstanding.",
             pending_ranges.size(), expected_fixes.size());
    $display("** trilateration_2d_ema_core: FAILED **");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/tri2d_pkg.sv
hdl/tri2d_ctrl.sv
hdl/tri2d_dp.sv
hdl/trilateration_2d_ema_core.sv
tb/tb_trilateration_2d_ema_core.sv
